/* sv/isrt_pkg.sv */
// types shared by the insertion sorter cells and the top level
// no dependencies
package isrt_pkg;

   localparam int unsigned DataWidth = 32;

   typedef logic signed [DataWidth-1:0] isrt_data_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic          occ;
      logic          gt;
      isrt_data_type data;
   } isrt_link_type;

   // operation applied to every cell of the row in the same cycle
   typedef struct packed {
      logic insert;
      logic shift;
   } isrt_ctrl_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } isrt_state_type;

endpackage

/* sv/isrt_cell.sv */
// one storage cell of the insertion sorter row
// depends on isrt_pkg
module isrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  isrt_pkg::isrt_ctrl_type ctrl,
   input  isrt_pkg::isrt_data_type new_value,
   input  isrt_pkg::isrt_link_type left,
   input  isrt_pkg::isrt_link_type right,
   output isrt_pkg::isrt_link_type link
);
   import isrt_pkg::*;

   isrt_data_type data_ff, data_in;
   logic          occ_ff, occ_in;
   logic          gt;

   assign gt = occ_ff & (data_ff > new_value);

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (ctrl.shift) begin
         data_in = right.data;
         occ_in  = right.occ;
      end else if (ctrl.insert) begin
         occ_in = occ_ff | left.occ;
         if (left.gt) begin
            data_in = left.data;
         end else if (gt | (~occ_ff & left.occ)) begin
            data_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link.occ  = occ_ff;
   assign link.gt   = gt;
   assign link.data = data_ff;

endmodule

/* sv/insertion_sorter_core.sv */
// insertion sorter: a row of SIZE compare-and-shift cells, depends on isrt_pkg and isrt_cell
// fill: one value a cycle, each inserted into the row in the cycle it transfers
// drain: the row shifts toward cell 0, one result a cycle while rsp_tready is high, SIZE results per set
// the first result is valid in the cycle after the SIZE-th input transfers
// synchronous reset empties the row and returns to fill
module insertion_sorter_core #(
   parameter int unsigned SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_value
   output logic        rsp_tlast    // final_res
);
   import isrt_pkg::*;

   isrt_state_type state_ff, state_in;
   isrt_ctrl_type  ctrl;
   isrt_link_type  links [SIZE];
   isrt_link_type  head_link, tail_link;
   isrt_data_type  new_value;
   logic           req_xfer, rsp_xfer;

   assign new_value  = isrt_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_FILL);
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_tvalid & rsp_tready;

   assign ctrl.insert = req_xfer;
   assign ctrl.shift  = rsp_xfer;

   assign head_link.occ  = 1'b1;
   assign head_link.gt   = 1'b0;
   assign head_link.data = '0;
   assign tail_link.occ  = 1'b0;
   assign tail_link.gt   = 1'b0;
   assign tail_link.data = '0;

   for (genvar i = 0; i < SIZE; i++) begin : g_cell
      isrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (new_value),
         .left      ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
         .right     ((i == SIZE - 1) ? tail_link : links[(i == SIZE - 1) ? i : i + 1]),
         .link      (links[i])
      );
   end

   assign rsp_tdata = links[0].data;
   assign rsp_tlast = ~links[1].occ;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_xfer && links[SIZE-2].occ) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer && rsp_tlast) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/isrt_checker.sv */
// port-level checks for insertion_sorter_core, bound into insertion_sorter_core
// no dependencies
module isrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_tvalid & rsp_tready;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open during drain");

   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tlast |=> rsp_tvalid)
      else $error("drain stopped before last");

   a_back_to_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("no return to fill after last");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tlast |=> $signed($past(rsp_tdata)) <= $signed(rsp_tdata))
      else $error("results out of order");

endmodule

bind insertion_sorter_core isrt_checker u_isrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench for insertion_sorter_core: streams sets of signed values through the sorter
// and checks every sorted result against a row of values kept in the bench
// depends on isrt_pkg and insertion_sorter_core
module testbench;
   import isrt_pkg::*;

   localparam int unsigned SetSize    = 16;
   localparam int unsigned CycleLimit = 200000;

   localparam isrt_data_type MinValue = 32'sh8000_0000;
   localparam isrt_data_type MaxValue = 32'sh7fff_ffff;

   typedef struct {
      isrt_data_type value;
      logic          last;
   } sorted_word_type;

   typedef enum logic [1:0] {
      StallNone,
      StallCoin,
      StallHeavy,
      StallPeriodic
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // sorted_value
   logic        rsp_tlast;   // final_res

   isrt_data_type   row_model [SetSize];
   int unsigned     row_fill = 0;
   sorted_word_type pending_sorted [$];

   int unsigned mismatches    = 0;
   int unsigned values_sent   = 0;
   int unsigned sets_done     = 0;
   int unsigned words_checked = 0;
   int unsigned cycle_count   = 0;
   int unsigned burst_left    = 0;

   stall_mode_type stall_mode  = StallNone;
   int unsigned    stall_left  = 0;
   int unsigned    stall_phase = 0;

   insertion_sorter_core #(.SIZE(SetSize)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   // stable insert: larger entries move up, equal ones stay ahead of the new value
   task automatic insert_into_row(input isrt_data_type v);
      int unsigned pos;
      sorted_word_type word;
      pos = row_fill;
      while (pos > 0 && row_model[pos-1] > v) begin
         row_model[pos] = row_model[pos-1];
         pos--;
      end
      row_model[pos] = v;
      row_fill++;
      if (row_fill == SetSize) begin
         for (int unsigned k = 0; k < SetSize; k++) begin
            word.value = row_model[k];
            word.last  = (k == SetSize - 1);
            pending_sorted.push_back(word);
         end
         row_fill = 0;
         sets_done++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      sorted_word_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            insert_into_row(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (pending_sorted.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_tdata, '0);
            end else begin
               want = pending_sorted.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("sorted value", rsp_tdata, want.value);
               if (rsp_tlast !== want.last)
                  report_mismatch("last mark", {31'd0, rsp_tlast}, {31'd0, want.last});
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_sorted.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver back-pressure, switching between patterns
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         StallNone:  rsp_tready <= 1'b1;
         StallCoin:  rsp_tready <= ($urandom_range(0, 1) == 1);
         StallHeavy: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:    rsp_tready <= (stall_phase % 3 != 0);
      endcase
   end

   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // one transfer on the input side, with bursts and gaps
   task automatic send_value(input isrt_data_type v);
      if (burst_left == 0) begin
         idle_cycles($urandom_range(0, 7));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      values_sent++;
   endtask

   task automatic wait_for_drain();
      idle_cycles(1);
      while (pending_sorted.size() != 0) @(posedge clock);
   endtask

   // descending first half forces full shifts, a pause checks a partial set stays quiet
   task automatic test_extremes_and_partial();
      isrt_data_type first_half [8];
      isrt_data_type second_half [8];
      first_half  = '{MaxValue, 32'sh7fff_fffe, 32'sh5555_5555, 32'sd1,
                      32'sd0, -32'sd1, 32'sh8000_0001, MinValue};
      second_half = '{32'sd0, MaxValue, MinValue, -32'sd1,
                      32'sd2, 32'shaaaa_aaaa, 32'shffff_0000, 32'sh0000_ffff};
      foreach (first_half[i]) send_value(first_half[i]);
      idle_cycles(3 * SetSize);
      foreach (second_half[i]) send_value(second_half[i]);
      wait_for_drain();
   endtask

   task automatic test_random_sets(input int unsigned sets);
      repeat (sets * SetSize) send_value($urandom);
      wait_for_drain();
   endtask

   // many equal values, either near one base or from MinValue, MaxValue, 0 and -1
   task automatic test_duplicate_sets(input int unsigned sets);
      isrt_data_type base;
      isrt_data_type v;
      for (int unsigned s = 0; s < sets; s++) begin
         base = $urandom;
         for (int unsigned k = 0; k < SetSize; k++) begin
            if (s % 2 == 0) begin
               v = base ^ $urandom_range(0, 3);
            end else begin
               case ($urandom_range(0, 3))
                  0:       v = MinValue;
                  1:       v = MaxValue;
                  2:       v = 32'sd0;
                  default: v = -32'sd1;
               endcase
            end
            send_value(v);
         end
      end
      wait_for_drain();
   endtask

   // ascending and descending runs
   task automatic test_ordered_sets(input int unsigned sets);
      isrt_data_type v;
      int unsigned step;
      for (int unsigned s = 0; s < sets; s++) begin
         v    = $urandom;
         step = $urandom_range(0, 1 << 20);
         for (int unsigned k = 0; k < SetSize; k++) begin
            send_value(v);
            v = (s % 2 == 0) ? v + step : v - step;
         end
      end
      wait_for_drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes_and_partial();
      test_random_sets(10);
      test_duplicate_sets(8);
      test_ordered_sets(7);

      wait_for_drain();
      repeat (2 * SetSize + 4) @(posedge clock);
      $display("sorted %0d sets from %0d values, %0d results compared, %0d mismatches",
               sets_done, values_sent, words_checked, mismatches);
      $display("covered extremes, partial-set pause, duplicates, ordered runs, random data");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/isrt_pkg.sv
sv/isrt_cell.sv
sv/insertion_sorter_core.sv
sv/isrt_checker.sv
bench/testbench.sv
